/* sv/itoa_pkg.sv */
`timescale 1ns / 1ps

package itoa_pkg;

  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharMinus  = 8'h2D;

  // input format codes
  localparam logic [2:0] KindUdec = 3'd0;
  localparam logic [2:0] KindSdec = 3'd1;
  localparam logic [2:0] KindHex  = 3'd2;
  localparam logic [2:0] KindOct  = 3'd3;
  localparam logic [2:0] KindBin  = 3'd4;

  typedef enum logic [1:0] {
    FmtDec,
    FmtHex,
    FmtOct,
    FmtBin
  } fmt_e;

  // One conversion job as the front hands it to the back.
  // last_pos is the index of the first digit to emit (binary only; others scan for it).
  typedef struct packed {
    fmt_e        fmt;
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  last_pos;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = CharUpperA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* sv/itoa_front.sv */
`timescale 1ns / 1ps

module itoa_front (
  input  logic [2:0]     kind_i,
  input  logic [31:0]    value_i,
  input  logic [5:0]     bit_count_i,
  output itoa_pkg::cmd_t cmd_o,
  output logic           keep_o
);

  logic [5:0] cnt_sat;

  assign cnt_sat = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;

  always_comb begin
    cmd_o.fmt      = itoa_pkg::FmtDec;
    cmd_o.neg      = 1'b0;
    cmd_o.mag      = value_i;
    cmd_o.last_pos = 5'(cnt_sat - 6'd1);
    keep_o         = 1'b1;
    unique case (kind_i)
      itoa_pkg::KindUdec: begin
        cmd_o.fmt = itoa_pkg::FmtDec;
      end
      itoa_pkg::KindSdec: begin
        cmd_o.fmt = itoa_pkg::FmtDec;
        cmd_o.neg = value_i[31];
        if (value_i[31]) begin
          cmd_o.mag = 32'd0 - value_i;
        end
      end
      itoa_pkg::KindHex: begin
        cmd_o.fmt = itoa_pkg::FmtHex;
      end
      itoa_pkg::KindOct: begin
        cmd_o.fmt = itoa_pkg::FmtOct;
      end
      itoa_pkg::KindBin: begin
        cmd_o.fmt = itoa_pkg::FmtBin;
        keep_o    = (cnt_sat != 6'd0);
      end
      default: begin
        // unused kinds produce no characters
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

/* sv/itoa_cmdq.sv */
`timescale 1ns / 1ps

module itoa_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  itoa_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output itoa_pkg::cmd_t rdata_o,
  output logic           empty_o
);

  itoa_pkg::cmd_t mem_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? ~wptr_q : wptr_q;
    rptr_d = do_rd ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* sv/itoa_back.sv */
`timescale 1ns / 1ps

module itoa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itoa_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_rd_o,
  output logic [7:0]     character_o,
  output logic           last_o,
  output logic           empty_o,
  input  logic           pop_i
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  itoa_pkg::fmt_e    fmt_q, fmt_d;
  logic              neg_q, neg_d;
  logic [31:0]       mag_q, mag_d;
  logic [39:0]       bcd_q, bcd_d;
  logic [4:0]        step_q, step_d;
  logic [4:0]        pos_q, pos_d;

  logic [39:0]       bcd_adj;
  logic [32:0]       oct_w;
  logic [4:0]        top_pos;
  logic [3:0]        cur_dig;

  // result queue, two entries
  logic [7:0]        oq_char_q [2];
  logic              oq_last_q [2];
  logic              oq_wptr_q, oq_rptr_q;
  logic [1:0]        oq_cnt_q;
  logic              oq_full, oq_wr, oq_rd;
  logic [7:0]        oq_char;
  logic              oq_last;

  assign oq_full     = (oq_cnt_q == 2'd2);
  assign empty_o     = (oq_cnt_q == 2'd0);
  assign oq_rd       = pop_i && !empty_o;
  assign character_o = oq_char_q[oq_rptr_q];
  assign last_o      = oq_last_q[oq_rptr_q];
  assign oct_w       = {1'b0, mag_q};

  // shift-add-3: bump every BCD digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // top digit index: highest nonzero digit (zero if none); binary keeps pos_q
  always_comb begin
    top_pos = 5'd0;
    case (fmt_q)
      itoa_pkg::FmtDec: begin
        for (int i = 0; i < 10; i++) begin
          if (bcd_q[4*i +: 4] != 4'd0) top_pos = 5'(i);
        end
      end
      itoa_pkg::FmtHex: begin
        for (int i = 0; i < 8; i++) begin
          if (mag_q[4*i +: 4] != 4'd0) top_pos = 5'(i);
        end
      end
      itoa_pkg::FmtOct: begin
        for (int i = 0; i < 11; i++) begin
          if (oct_w[3*i +: 3] != 3'd0) top_pos = 5'(i);
        end
      end
      default: begin
        top_pos = pos_q;
      end
    endcase
  end

  always_comb begin
    cur_dig = 4'd0;
    case (fmt_q)
      itoa_pkg::FmtDec: begin
        for (int i = 0; i < 10; i++) begin
          if (pos_q == 5'(i)) cur_dig = bcd_q[4*i +: 4];
        end
      end
      itoa_pkg::FmtHex: begin
        cur_dig = mag_q[4*pos_q[2:0] +: 4];
      end
      itoa_pkg::FmtOct: begin
        for (int i = 0; i < 11; i++) begin
          if (pos_q == 5'(i)) cur_dig = {1'b0, oct_w[3*i +: 3]};
        end
      end
      default: begin
        cur_dig = {3'd0, mag_q[pos_q]};
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    fmt_d    = fmt_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    step_d   = step_q;
    pos_d    = pos_q;
    cmd_rd_o = 1'b0;
    oq_wr    = 1'b0;
    oq_char  = itoa_pkg::digit_char(cur_dig);
    oq_last  = (pos_q == 5'd0);
    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_rd_o = 1'b1;
          fmt_d    = cmd_i.fmt;
          neg_d    = cmd_i.neg;
          mag_d    = cmd_i.mag;
          pos_d    = cmd_i.last_pos;
          bcd_d    = '0;
          step_d   = 5'd0;
          state_d  = (cmd_i.fmt == itoa_pkg::FmtDec) ? StConv : StScan;
        end
      end
      StConv: begin
        {bcd_d, mag_d} = {bcd_adj[38:0], mag_q, 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          state_d = StScan;
        end
      end
      StScan: begin
        pos_d   = top_pos;
        state_d = StEmit;
      end
      StEmit: begin
        if (!oq_full) begin
          oq_wr = 1'b1;
          if (neg_q) begin
            oq_char = itoa_pkg::CharMinus;
            oq_last = 1'b0;
            neg_d   = 1'b0;
          end else if (pos_q == 5'd0) begin
            state_d = StIdle;
          end else begin
            pos_d = pos_q - 5'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      neg_q   <= 1'b0;
      step_q  <= 5'd0;
      pos_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      step_q  <= step_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fmt_q <= fmt_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q <= 1'b0;
      oq_rptr_q <= 1'b0;
      oq_cnt_q  <= 2'd0;
    end else begin
      if (oq_wr) oq_wptr_q <= ~oq_wptr_q;
      if (oq_rd) oq_rptr_q <= ~oq_rptr_q;
      if (oq_wr && !oq_rd) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (oq_rd && !oq_wr) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_char_q[oq_wptr_q] <= oq_char;
      oq_last_q[oq_wptr_q] <= oq_last;
    end
  end

endmodule

/* sv/integer_to_ascii_radix_converter_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// input     in         push / full    kind_i[2:0], value_i[31:0], bit_count_i[5:0]
// result    out        pop / empty    character_o[7:0], last_o
//
// Decimal items take a load, 32 shift-add-3 steps and a digit scan, then one
// character per cycle (up to 11) while the result queue has room; hex, octal and
// binary take a load and a scan first. The back sequencer handles one item at a time.
// Reset clears the two-entry command queue, the two-entry result queue and the sequencer.
// full rises when the command queue holds two jobs; the sequencer stalls while the
// result queue is full. Items that give no characters are taken and dropped.

module integer_to_ascii_radix_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  bit_count_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  character_o,
  output logic        last_o
);

  itoa_pkg::cmd_t front_cmd;
  itoa_pkg::cmd_t q_cmd;
  logic           front_keep;
  logic           q_wr;
  logic           q_empty;
  logic           q_rd;

  assign q_wr = push && !full && front_keep;

  itoa_front u_front (
    .kind_i      (kind_i),
    .value_i     (value_i),
    .bit_count_i (bit_count_i),
    .cmd_o       (front_cmd),
    .keep_o      (front_keep)
  );

  itoa_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (front_cmd),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_cmd),
    .empty_o (q_empty)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_empty_i (q_empty),
    .cmd_rd_o    (q_rd),
    .character_o (character_o),
    .last_o      (last_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
